>>> sv/kwmq_pkg.sv
// ----------------------------------------------------------------------------
// kwmq_pkg
// Shared types, codes and the ordering rule of the k-way merge min queue.
// ----------------------------------------------------------------------------
package kwmq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int VALUE_W     = 32;
  localparam int SRC_W       = 4;
  localparam int OCC_W       = 5;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_REPLACE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_EXTRACT,
    OP_REPLACE
  } op_t;

  typedef struct packed {
    op_t op;
  } cell_ctl_t;

  // true when entry a leaves before entry b
  function automatic logic goes_first(input logic signed [63:0] ka,
                                      input logic [SRC_W-1:0] sa,
                                      input logic signed [63:0] kb,
                                      input logic [SRC_W-1:0] sb);
    goes_first = (ka < kb) || ((ka == kb) && (sa < sb));
  endfunction

endpackage

>>> sv/kwmq_cell.sv
// ----------------------------------------------------------------------------
// kwmq_cell
// One slot of the sorted register chain: keep, take the new entry, or take
// the entry of a neighbour.
// ----------------------------------------------------------------------------
module kwmq_cell #(
  parameter int KEY_WIDTH = kwmq_pkg::KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  kwmq_pkg::cell_ctl_t         ctl,
  input  logic                        head,
  input  logic                        valid,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic [kwmq_pkg::SRC_W-1:0]  new_src,
  input  logic signed [KEY_WIDTH-1:0] prev_key,
  input  logic [kwmq_pkg::SRC_W-1:0]  prev_src,
  input  logic                        prev_lt,
  input  logic signed [KEY_WIDTH-1:0] next_key,
  input  logic [kwmq_pkg::SRC_W-1:0]  next_src,
  input  logic                        next_lt,
  output logic signed [KEY_WIDTH-1:0] key_r,
  output logic [kwmq_pkg::SRC_W-1:0]  src_r,
  output logic                        lt
);

  logic signed [KEY_WIDTH-1:0] key_nxt;
  logic [kwmq_pkg::SRC_W-1:0]  src_nxt;

  assign lt = valid && kwmq_pkg::goes_first(64'(key_r), src_r, 64'(new_key), new_src);

  always_comb begin
    key_nxt = key_r;
    src_nxt = src_r;
    unique case (ctl.op)
      kwmq_pkg::OP_INSERT: begin
        if (!lt) begin
          if (prev_lt) begin
            key_nxt = new_key;
            src_nxt = new_src;
          end else begin
            key_nxt = prev_key;
            src_nxt = prev_src;
          end
        end
      end
      kwmq_pkg::OP_EXTRACT: begin
        key_nxt = next_key;
        src_nxt = next_src;
      end
      kwmq_pkg::OP_REPLACE: begin
        if (next_lt) begin
          key_nxt = next_key;
          src_nxt = next_src;
        end else if (head || lt) begin
          key_nxt = new_key;
          src_nxt = new_src;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    src_r <= src_nxt;
  end

endmodule

>>> sv/k_way_merge_min_queue.sv
// ----------------------------------------------------------------------------
// k_way_merge_min_queue
// Bounded min-priority queue for a k-way merge, built as a sorted chain of
// cells with the smallest entry always in the head cell.
// Result: the result word of an accepted word is registered and valid from the next cycle.
// Throughput: one word per cycle while out_tready is high; each cell makes
// one key compare per cycle against the incoming entry.
// Reset: queue empty, no result pending; stored entries are not cleared.
// ----------------------------------------------------------------------------
module k_way_merge_min_queue #(
  parameter int CAPACITY  = kwmq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = kwmq_pkg::KEY_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kwmq_pkg::IN_TDATA_W-1:0]     in_tdata,  // in_value, in_source
  input  logic [kwmq_pkg::CMD_W-1:0]          in_tuser,  // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kwmq_pkg::OUT_TDATA_W-1:0]    out_tdata, // out_value, out_source, occupancy
  output logic [kwmq_pkg::OUT_TUSER_W-1:0]    out_tuser  // out_valid, status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                               acc;
  logic [CW-1:0]                      count_r, count_nxt;
  logic signed [kwmq_pkg::VALUE_W-1:0] in_value;
  logic [kwmq_pkg::SRC_W-1:0]         in_source;
  logic signed [KEY_WIDTH-1:0]        new_key;
  kwmq_pkg::cell_ctl_t                ctl;
  logic                               empty, full;
  logic                               res_valid;
  kwmq_pkg::status_t                  res_status;

  logic signed [KEY_WIDTH-1:0]        key_a  [CAPACITY];
  logic [kwmq_pkg::SRC_W-1:0]         src_a  [CAPACITY];
  logic                               lt_a   [CAPACITY];
  logic                               vld_a  [CAPACITY];
  logic signed [KEY_WIDTH-1:0]        pkey_a [CAPACITY];
  logic [kwmq_pkg::SRC_W-1:0]         psrc_a [CAPACITY];
  logic                               plt_a  [CAPACITY];
  logic signed [KEY_WIDTH-1:0]        nkey_a [CAPACITY];
  logic [kwmq_pkg::SRC_W-1:0]         nsrc_a [CAPACITY];
  logic                               nlt_a  [CAPACITY];

  logic                               out_tvalid_r;
  logic signed [kwmq_pkg::VALUE_W-1:0] out_value_r;
  logic [kwmq_pkg::SRC_W-1:0]         out_source_r;
  logic                               out_valid_r;
  kwmq_pkg::status_t                  out_status_r;
  logic [kwmq_pkg::OCC_W-1:0]         out_occ_r;

  assign in_tready = !out_tvalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign in_value  = in_tdata[31:0];
  assign in_source = in_tdata[35:32];
  assign new_key   = KEY_WIDTH'(in_value);
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(CAPACITY));

  always_comb begin
    ctl.op     = kwmq_pkg::OP_HOLD;
    count_nxt  = count_r;
    res_valid  = 1'b0;
    res_status = kwmq_pkg::ST_OK;
    unique case (in_tuser)
      kwmq_pkg::CMD_INSERT: begin
        if (full) begin
          res_status = kwmq_pkg::ST_FULL;
        end else begin
          ctl.op    = kwmq_pkg::OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      kwmq_pkg::CMD_EXTRACT: begin
        if (empty) begin
          res_status = kwmq_pkg::ST_EMPTY;
        end else begin
          ctl.op    = kwmq_pkg::OP_EXTRACT;
          count_nxt = count_r - 1'b1;
          res_valid = 1'b1;
        end
      end
      kwmq_pkg::CMD_REPLACE: begin
        if (empty) begin
          res_status = kwmq_pkg::ST_EMPTY;
          ctl.op     = kwmq_pkg::OP_INSERT;
          count_nxt  = count_r + 1'b1;
        end else begin
          ctl.op    = kwmq_pkg::OP_REPLACE;
          res_valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!acc) begin
      ctl.op    = kwmq_pkg::OP_HOLD;
      count_nxt = count_r;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vld_a[i] = (count_r > CW'(i));
      if (i == 0) begin
        pkey_a[i] = '0;
        psrc_a[i] = '0;
        plt_a[i]  = 1'b1;
      end else begin
        pkey_a[i] = key_a[i-1];
        psrc_a[i] = src_a[i-1];
        plt_a[i]  = lt_a[i-1];
      end
      if (i == CAPACITY - 1) begin
        nkey_a[i] = '0;
        nsrc_a[i] = '0;
        nlt_a[i]  = 1'b0;
      end else begin
        nkey_a[i] = key_a[i+1];
        nsrc_a[i] = src_a[i+1];
        nlt_a[i]  = lt_a[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    kwmq_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .head     (g == 0),
      .valid    (vld_a[g]),
      .new_key  (new_key),
      .new_src  (in_source),
      .prev_key (pkey_a[g]),
      .prev_src (psrc_a[g]),
      .prev_lt  (plt_a[g]),
      .next_key (nkey_a[g]),
      .next_src (nsrc_a[g]),
      .next_lt  (nlt_a[g]),
      .key_r    (key_a[g]),
      .src_r    (src_a[g]),
      .lt       (lt_a[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_value_r  <= res_valid ? kwmq_pkg::VALUE_W'(key_a[0]) : '0;
      out_source_r <= res_valid ? src_a[0] : '0;
      out_valid_r  <= res_valid;
      out_status_r <= res_status;
      out_occ_r    <= kwmq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_occ_r, out_source_r, out_value_r};
  assign out_tuser  = {out_status_r, out_valid_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == kwmq_pkg::CMD_EXTRACT) && (count_r == '0)
    |=> out_tvalid && !out_valid_r && (out_status_r == kwmq_pkg::ST_EMPTY))
    else $error("extract on empty not flagged");

  a_head_min: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CW'(1))
    |-> !kwmq_pkg::goes_first(64'(key_a[1]), src_a[1], 64'(key_a[0]), src_a[0]))
    else $error("head cell not the minimum");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_tuser == kwmq_pkg::CMD_INSERT) && (count_r == CW'(CAPACITY))
    |=> (count_r == CW'(CAPACITY)) && (out_status_r == kwmq_pkg::ST_FULL))
    else $error("insert on full queue not dropped");

endmodule

>>> dv/tb_k_way_merge_min_queue.sv
// ----------------------------------------------------------------------------
// tb_k_way_merge_min_queue
// Self-checking bench for the k-way merge min queue. A clocked driver feeds
// command words from a queue built up front: a directed opening, then
// randomised merge rounds (load k streams, replace from random streams,
// drain) mixed with noise. A clocked monitor keeps its own model of the held
// entries, predicts one result word per accepted command and compares every
// field. Both ports idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_k_way_merge_min_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                        CAP        = kwmq_pkg::CAPACITY_DEF;
  localparam logic [kwmq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [kwmq_pkg::CMD_W-1:0]    cmd;
    logic signed [31:0]            value;
    logic [kwmq_pkg::SRC_W-1:0]    src;
    int                            gap;
    bit                            pause;
  } merge_cmd_t;

  typedef struct {
    logic signed [31:0]            value;
    logic [kwmq_pkg::SRC_W-1:0]    src;
    logic                          valid;
    logic [kwmq_pkg::STATUS_W-1:0] status;
    logic [kwmq_pkg::OCC_W-1:0]    occ;
  } merge_res_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [kwmq_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [kwmq_pkg::CMD_W-1:0]       in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [kwmq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [kwmq_pkg::OUT_TUSER_W-1:0] out_tuser;

  merge_cmd_t                 merge_cmds[$];
  merge_res_t                 pending_results[$];
  logic signed [31:0]         held_key [CAP];
  logic [kwmq_pkg::SRC_W-1:0] held_src [CAP];
  int                         held_cnt        = 0;
  int                         err_cnt         = 0;
  int                         accepted_cnt    = 0;
  bit                         in_taken        = 1'b0;
  bit                         offering        = 1'b0;
  int                         gap_left        = 0;
  int                         stall_left      = 0;
  int                         long_hold_left  = 0;
  bit                         long_hold_done  = 1'b0;
  int                         rx_cycles       = 0;

  k_way_merge_min_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic signed [31:0] pick_key(bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 20) - 10;
  endfunction

  task automatic add_cmd(logic [kwmq_pkg::CMD_W-1:0] cmd, logic signed [31:0] value,
                         logic [kwmq_pkg::SRC_W-1:0] src, bit calm);
    merge_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    c.src   = src;
    c.gap   = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    c.pause = 1'b0;
    merge_cmds.push_back(c);
  endtask

  task automatic add_pause();
    merge_cmd_t c;
    c       = '{default: '0};
    c.pause = 1'b1;
    merge_cmds.push_back(c);
  endtask

  // remove the smallest (key, source) first, then append any new entry
  function automatic merge_res_t merge_queue_step(logic [kwmq_pkg::CMD_W-1:0] cmd,
                                                  logic signed [31:0] value,
                                                  logic [kwmq_pkg::SRC_W-1:0] src);
    merge_res_t r;
    int best;
    r        = '{default: '0};
    r.status = kwmq_pkg::ST_OK;
    if (cmd == kwmq_pkg::CMD_EXTRACT || cmd == kwmq_pkg::CMD_REPLACE) begin
      if (held_cnt == 0) begin
        r.status = kwmq_pkg::ST_EMPTY;
      end else begin
        best = 0;
        for (int i = 1; i < held_cnt; i++) begin
          if (held_key[i] < held_key[best] ||
              (held_key[i] == held_key[best] && held_src[i] < held_src[best])) begin
            best = i;
          end
        end
        r.valid  = 1'b1;
        r.value  = held_key[best];
        r.src    = held_src[best];
        held_cnt = held_cnt - 1;
        held_key[best] = held_key[held_cnt];
        held_src[best] = held_src[held_cnt];
      end
    end
    if (cmd == kwmq_pkg::CMD_INSERT || cmd == kwmq_pkg::CMD_REPLACE) begin
      if (held_cnt >= CAP) begin
        r.status = kwmq_pkg::ST_FULL;
      end else begin
        held_key[held_cnt] = value;
        held_src[held_cnt] = src;
        held_cnt = held_cnt + 1;
      end
    end
    r.occ = held_cnt[kwmq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken && offering) begin
        void'(merge_cmds.pop_front());
        offering = 1'b0;
        if (merge_cmds.size() != 0) gap_left = merge_cmds[0].gap;
      end
      if (!offering && merge_cmds.size() != 0) begin
        if (merge_cmds[0].pause) begin
          if (pending_results.size() == 0) begin
            void'(merge_cmds.pop_front());
            if (merge_cmds.size() != 0) gap_left = merge_cmds[0].gap;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          offering = 1'b1;
        end
      end
      in_tvalid <= offering;
      if (offering) begin
        in_tdata <= {4'b0, merge_cmds[0].src, merge_cmds[0].value};
        in_tuser <= merge_cmds[0].cmd;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycles++;
      if (!long_hold_done && accepted_cnt >= 200) begin
        long_hold_left = 80;
        long_hold_done = 1'b1;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ((rx_cycles / 300) % 4 != 3 && $urandom_range(0, 99) < 20) begin
        stall_left = gap_len();
      end
      out_tready <= (long_hold_left == 0 && stall_left == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    merge_res_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no command outstanding");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_value", want.value, $signed(out_tdata[31:0]));
          check_field("out_source", want.src, out_tdata[35:32]);
          check_field("occupancy", want.occ, out_tdata[40:36]);
          check_field("out_valid", want.valid, out_tuser[0]);
          check_field("status", want.status, out_tuser[2:1]);
        end
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        pending_results.push_back(merge_queue_step(in_tuser, in_tdata[31:0],
                                                   in_tdata[35:32]));
        accepted_cnt++;
      end
    end
  end

  initial begin
    logic signed [31:0] last [16];
    int  k, reps, n, s, n_rand, round;
    bit  wide, calm;

    add_cmd(kwmq_pkg::CMD_EXTRACT, 0, 4'd0, 1'b0);
    add_cmd(kwmq_pkg::CMD_REPLACE, 7, 4'd2, 1'b0);
    add_cmd(CMD_UNUSED, 32'h5a5a_a5a5, 4'ha, 1'b0);
    add_cmd(kwmq_pkg::CMD_EXTRACT, 0, 4'd0, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, 32'h7fff_ffff, 4'd0, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, 32'h8000_0000, 4'd15, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, 0, 4'd6, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, -1, 4'd12, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, 5, 4'd9, 1'b0);
    add_cmd(kwmq_pkg::CMD_INSERT, 5, 4'd3, 1'b0);
    for (int i = 0; i < 10; i++) begin
      add_cmd(kwmq_pkg::CMD_INSERT, $urandom,
              kwmq_pkg::SRC_W'($urandom_range(0, 15)), 1'b0);
    end
    add_cmd(kwmq_pkg::CMD_INSERT, 123, 4'd5, 1'b0);
    add_cmd(kwmq_pkg::CMD_REPLACE, -7, 4'd1, 1'b0);
    add_cmd(kwmq_pkg::CMD_EXTRACT, 0, 4'd0, 1'b0);
    add_cmd(kwmq_pkg::CMD_EXTRACT, 0, 4'd0, 1'b0);
    add_cmd(CMD_UNUSED, 32'ha5a5_5a5a, 4'h5, 1'b0);
    add_pause();

    n_rand = 0;
    round  = 0;
    while (n_rand < 800) begin
      round++;
      calm = (round % 5 == 0);
      if (round == 12) add_pause();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 12; i++) begin
          add_cmd(kwmq_pkg::CMD_W'($urandom_range(0, 3)), $urandom,
                  kwmq_pkg::SRC_W'($urandom_range(0, 15)), calm);
        end
        n_rand += 12;
      end else begin
        wide = ($urandom_range(0, 2) == 0);
        k    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
        for (s = 0; s < 16; s++) last[s] = pick_key(wide);
        for (s = 0; s < k; s++) begin
          add_cmd(kwmq_pkg::CMD_INSERT, last[s % 16], kwmq_pkg::SRC_W'(s % 16), calm);
        end
        reps = $urandom_range(k, 3 * k);
        for (int i = 0; i < reps; i++) begin
          s       = $urandom_range(0, 15);
          last[s] = last[s] + $urandom_range(0, 4);
          add_cmd(kwmq_pkg::CMD_REPLACE, last[s], kwmq_pkg::SRC_W'(s), calm);
        end
        n = k + $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          add_cmd(kwmq_pkg::CMD_EXTRACT, $urandom,
                  kwmq_pkg::SRC_W'($urandom_range(0, 15)), calm);
        end
        n_rand += k + reps + n;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (merge_cmds.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
sv/kwmq_pkg.sv
sv/kwmq_cell.sv
sv/k_way_merge_min_queue.sv
dv/tb_k_way_merge_min_queue.sv
